>>> hdl/zdc_ep_pkg.sv
// shared types, constants and lookup functions of the event-plane angle block
package zdc_ep_pkg;

  localparam int ENERGY_BITS_DEF = 16;
  localparam int IDX_W           = 6;
  localparam int SUM_W           = 40;
  localparam int COEF_W          = 17;
  localparam int ANGLE_W         = 16;
  localparam int CORDIC_W        = 43;
  localparam int Z_W             = 18;
  localparam int TURN_W          = 14;
  localparam int STEPS           = 16;
  localparam int STEP_W          = 4;
  localparam int MODULES         = 45;
  localparam int CENTRAL_MODULE  = 22;
  localparam int PITCH_ROW       = 7;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [Z_W-1:0]   Z_HALF  = Z_W'(32768);

  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_v;
    logic signed [COEF_W-1:0] sin_v;
  } coef_t;

  // q15 magnitude of a/sqrt(a^2+b^2), rounded to nearest
  function automatic logic [COEF_W-1:0] q15_mag(input logic [1:0] a, input logic [1:0] b);
    logic [COEF_W-1:0] m;
    if (a == 2'd0) m = '0;
    else if (b == 2'd0) m = COEF_W'(32768);
    else if (a == b) m = COEF_W'(23170);
    else begin
      unique case ({a, b})
        4'b0110: m = COEF_W'(14654);
        4'b1001: m = COEF_W'(29309);
        4'b0111: m = COEF_W'(10362);
        4'b1101: m = COEF_W'(31086);
        4'b1011: m = COEF_W'(18176);
        4'b1110: m = COEF_W'(27265);
        default: m = '0;
      endcase
    end
    return m;
  endfunction

  // cosine and sine of a module azimuth; unused modules and the central module give zero
  function automatic coef_t coef_of(input logic [IDX_W-1:0] idx);
    int xi;
    int yi;
    int k;
    int row;
    logic [1:0] ax;
    logic [1:0] ay;
    logic [COEF_W-1:0] cm;
    logic [COEF_W-1:0] sm;
    coef_t r;
    k   = int'(idx) + 2;
    row = 0;
    if (idx <= IDX_W'(4)) begin
      yi = 3;
      xi = int'(idx) - 2;
    end else if (idx <= IDX_W'(39)) begin
      if (k < 2 * PITCH_ROW) row = 1;
      else if (k < 3 * PITCH_ROW) row = 2;
      else if (k < 4 * PITCH_ROW) row = 3;
      else if (k < 5 * PITCH_ROW) row = 4;
      else row = 5;
      yi = 3 - row;
      xi = 3 - (k - PITCH_ROW * row);
    end else begin
      yi = -3;
      xi = int'(idx) - 42;
    end
    ax = (xi < 0) ? 2'(-xi) : 2'(xi);
    ay = (yi < 0) ? 2'(-yi) : 2'(yi);
    cm = q15_mag(ax, ay);
    sm = q15_mag(ay, ax);
    r.cos_v = (xi < 0) ? -$signed(cm) : $signed(cm);
    r.sin_v = (yi < 0) ? -$signed(sm) : $signed(sm);
    if (idx >= IDX_W'(MODULES) || idx == IDX_W'(CENTRAL_MODULE)) r = '0;
    return r;
  endfunction

  // arctangent of 2^-i in units of pi/32768
  function automatic logic [TURN_W-1:0] turn_of(input logic [STEP_W-1:0] i);
    logic [TURN_W-1:0] t;
    unique case (i)
      4'd0:  t = TURN_W'(8192);
      4'd1:  t = TURN_W'(4836);
      4'd2:  t = TURN_W'(2555);
      4'd3:  t = TURN_W'(1297);
      4'd4:  t = TURN_W'(651);
      4'd5:  t = TURN_W'(326);
      4'd6:  t = TURN_W'(163);
      4'd7:  t = TURN_W'(81);
      4'd8:  t = TURN_W'(41);
      4'd9:  t = TURN_W'(20);
      4'd10: t = TURN_W'(10);
      4'd11: t = TURN_W'(5);
      4'd12: t = TURN_W'(3);
      4'd13: t = TURN_W'(1);
      4'd14: t = TURN_W'(1);
      4'd15: t = TURN_W'(0);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

>>> hdl/zdc_ep_acc.sv
// q-vector accumulator: one shared multiplier and one shared saturating adder
module zdc_ep_acc import zdc_ep_pkg::*; #(
  parameter int ENERGY_BITS = ENERGY_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  acc_ctrl_t               ctrl_i,
  input  logic [IDX_W-1:0]        module_index_i,
  input  logic [ENERGY_BITS-1:0]  module_energy_i,
  output logic                    done_o,
  output logic signed [SUM_W-1:0] sum_cos_o,
  output logic signed [SUM_W-1:0] sum_sin_o
);

  typedef enum logic [3:0] {
    A_IDLE  = 4'b0001,
    A_MUL   = 4'b0010,
    A_ADD_C = 4'b0100,
    A_ADD_S = 4'b1000
  } acc_state_e;

  acc_state_e state_q, state_d;
  logic [ENERGY_BITS-1:0]  energy_q;
  coef_t                   coef_q;
  logic signed [SUM_W-1:0] prod_q, prod_d;
  logic signed [SUM_W-1:0] sum_cos_q, sum_cos_d, sum_sin_q, sum_sin_d;

  logic signed [COEF_W-1:0]             mul_coef;
  logic signed [ENERGY_BITS+COEF_W:0]   mul_full;
  logic signed [SUM_W-1:0]              add_a;
  logic        [SUM_W:0]                add_full;
  logic signed [SUM_W-1:0]              add_sat;

  // shared multiplier: cosine first, then sine
  assign mul_coef = (state_q == A_MUL) ? coef_q.cos_v : coef_q.sin_v;
  assign mul_full = $signed({1'b0, energy_q}) * mul_coef;
  assign prod_d   = SUM_W'(mul_full);

  // shared saturating adder
  assign add_a    = (state_q == A_ADD_C) ? sum_cos_q : sum_sin_q;
  assign add_full = {add_a[SUM_W-1], add_a} + {prod_q[SUM_W-1], prod_q};
  always_comb begin
    if (add_full[SUM_W] != add_full[SUM_W-1]) begin
      add_sat = add_full[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      add_sat = $signed(add_full[SUM_W-1:0]);
    end
  end

  always_comb begin
    state_d   = state_q;
    sum_cos_d = sum_cos_q;
    sum_sin_d = sum_sin_q;
    unique case (state_q)
      A_IDLE: begin
        if (ctrl_i.start) state_d = A_MUL;
      end
      A_MUL: state_d = A_ADD_C;
      A_ADD_C: begin
        sum_cos_d = add_sat;
        state_d   = A_ADD_S;
      end
      A_ADD_S: begin
        sum_sin_d = add_sat;
        state_d   = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
    if (ctrl_i.clear) begin
      sum_cos_d = '0;
      sum_sin_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= A_IDLE;
      sum_cos_q <= '0;
      sum_sin_q <= '0;
    end else begin
      state_q   <= state_d;
      sum_cos_q <= sum_cos_d;
      sum_sin_q <= sum_sin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == A_IDLE && ctrl_i.start) begin
      energy_q <= module_energy_i;
      coef_q   <= coef_of(module_index_i);
    end
    prod_q <= prod_d;
  end

  assign done_o    = (state_q == A_ADD_S);
  assign sum_cos_o = sum_cos_q;
  assign sum_sin_o = sum_sin_q;

endmodule

>>> hdl/zdc_ep_cordic.sv
// iterative vectoring cordic, one rotation step per cycle
module zdc_ep_cordic import zdc_ep_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [SUM_W-1:0]   q_x_i,
  input  logic signed [SUM_W-1:0]   q_y_i,
  output logic                      done_o,
  output logic signed [ANGLE_W-1:0] angle_o
);

  typedef enum logic [1:0] {
    C_IDLE = 2'b01,
    C_RUN  = 2'b10
  } cordic_state_e;

  cordic_state_e state_q, state_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]      z_q, z_d;
  logic                       zero_q, zero_d;

  logic signed [CORDIC_W-1:0] qx_ext, qy_ext, dx, dy;
  logic signed [Z_W-1:0]      turn;
  logic                       neg;

  assign qx_ext = CORDIC_W'(q_x_i);
  assign qy_ext = CORDIC_W'(q_y_i);
  assign neg    = q_x_i[SUM_W-1];
  assign dx     = y_q >>> step_q;
  assign dy     = x_q >>> step_q;
  assign turn   = $signed({{(Z_W-TURN_W){1'b0}}, turn_of(step_q)});

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    zero_d  = zero_q;
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          // fold the left half-plane onto the right one
          x_d     = neg ? -qx_ext : qx_ext;
          y_d     = neg ? -qy_ext : qy_ext;
          z_d     = neg ? (q_y_i[SUM_W-1] ? -Z_HALF : Z_HALF) : '0;
          zero_d  = (q_x_i == '0) && (q_y_i == '0);
          step_d  = '0;
          state_d = C_RUN;
        end
      end
      C_RUN: begin
        if (!y_q[CORDIC_W-1]) begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + turn;
        end else begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - turn;
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(STEPS - 1)) state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  assign done_o  = (state_q == C_RUN) && (step_q == STEP_W'(STEPS - 1));
  assign angle_o = zero_q ? '0 : $signed(z_q[ANGLE_W-1:0]);

endmodule

>>> hdl/zdc_event_plane_angle_top.sv
// top level of the zdc event-plane angle block: sequencer, input and result registers
//
// channel   direction  tdata fields, lowest bit first              tlast
// s_axis    in         module_index[5:0], module_energy, zero pad  last_module
// m_axis    out        plane_angle[15:0], q_x[55:16], q_y[95:56]    -
//
// a request passes from acceptance until tready is back through a multiply step, then a
// cosine add and a sine add in the shared multiply/saturating-add unit
// a request with tlast then adds a cordic load, 16 cordic steps on the shared shift/add
// unit, and a move of the result into the output register once that register is free
// tready is high only while the sequencer is idle; a result waiting in the
// output register does not block new requests, only the next result
// reset is asynchronous and active low; it clears both sums and all control state
module zdc_event_plane_angle_top import zdc_ep_pkg::*; #(
  parameter int ENERGY_BITS = ENERGY_BITS_DEF,
  localparam int InW = ((IDX_W + ENERGY_BITS + 7) / 8) * 8,
  localparam int OutW = ANGLE_W + 2 * SUM_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // module_index, module_energy, zero pad
  input  logic [InW-1:0]  s_axis_tdata_i,
  input  logic            s_axis_tlast_i,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // plane_angle, q_x, q_y
  output logic [OutW-1:0] m_axis_tdata_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i
);

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ACC    = 5'b00010,
    S_CSTART = 5'b00100,
    S_ANGLE  = 5'b01000,
    S_OUT    = 5'b10000
  } top_state_e;

  top_state_e state_q, state_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;
  logic signed [ANGLE_W-1:0] angle_out_q;
  logic signed [SUM_W-1:0]   qx_out_q, qy_out_q;

  acc_ctrl_t               acc_ctrl;
  logic                    acc_done;
  logic signed [SUM_W-1:0] sum_cos, sum_sin;
  logic                    cordic_start, cordic_done;
  logic signed [ANGLE_W-1:0] angle;

  logic in_fire;
  logic out_free;
  logic out_load;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  // output register can take a new result when empty or being drained
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign out_load        = (state_q == S_OUT) && out_free;

  // sums clear as the result moves out
  assign acc_ctrl.start = in_fire;
  assign acc_ctrl.clear = out_load;
  assign cordic_start   = (state_q == S_CSTART);

  zdc_ep_acc #(
    .ENERGY_BITS(ENERGY_BITS)
  ) u_acc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (acc_ctrl),
    .module_index_i (s_axis_tdata_i[IDX_W-1:0]),
    .module_energy_i(s_axis_tdata_i[IDX_W +: ENERGY_BITS]),
    .done_o         (acc_done),
    .sum_cos_o      (sum_cos),
    .sum_sin_o      (sum_sin)
  );

  zdc_ep_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cordic_start),
    .q_x_i  (sum_cos),
    .q_y_i  (sum_sin),
    .done_o (cordic_done),
    .angle_o(angle)
  );

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          last_d  = s_axis_tlast_i;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        // the sine sum is updated at the end of the acc done cycle, the cosine sum before it
        if (acc_done) state_d = last_q ? S_CSTART : S_IDLE;
      end
      S_CSTART: state_d = S_ANGLE;
      S_ANGLE: begin
        if (cordic_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      angle_out_q <= angle;
      qx_out_q    <= sum_cos;
      qy_out_q    <= sum_sin;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {qy_out_q, qx_out_q, angle_out_q};

  // a new result only appears out of the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_OUT))
    else $error("result valid without a finished angle");

  // accumulator completes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done |-> (state_q == S_ACC))
    else $error("accumulator done outside the acc state");

  // cordic completes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_done |-> (state_q == S_ANGLE))
    else $error("cordic done outside the angle state");

  // sums start from zero after each delivered event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (sum_cos == '0 && sum_sin == '0))
    else $error("sums not cleared after a result");

endmodule
